@@ design/msdw_pkg.sv @@
// shared types and constants for the distinct-window maximum sum block
package msdw_pkg;

   localparam int VALUE_W = 20;
   localparam int SUM_W   = 26;
   localparam int LEN_W   = 7;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } msdw_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] best_sum;
      logic [SUM_W-1:0] window_sum;
      logic             window_ok;
      logic             final_res;
   } msdw_rsp_type;

   // per-transaction flags travelling with the scan results
   typedef struct packed {
      logic last;
      logic full;
   } msdw_tag_type;

endpackage

@@ design/msdw_window.sv @@
// window shift register and fill counter, newest value in cell 0
module msdw_window import msdw_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int VALUE_BITS = 20,
   localparam int KW = $clog2(WINDOW_MAX + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic [VALUE_BITS-1:0]                value_in,
   input  logic                                 last_in,
   output logic [WINDOW_MAX-1:0][VALUE_BITS-1:0] cells,
   output logic [KW-1:0]                        fill,
   output logic                                 last
);

   logic [WINDOW_MAX-1:0][VALUE_BITS-1:0] cells_ff;
   logic [WINDOW_MAX-1:0][VALUE_BITS-1:0] cells_in;
   logic [KW-1:0]                         fill_ff;
   logic [KW-1:0]                         fill_in;
   logic                                  last_ff;

   // cells past the fill count are never looked at, so a new sequence only restarts the count
   always_comb begin
      cells_in = {cells_ff[WINDOW_MAX-2:0], value_in};
      if (last_ff) begin
         fill_in = KW'(1);
      end else if (fill_ff == KW'(WINDOW_MAX)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cells_ff <= cells_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         last_ff <= 1'b0;
      end else if (load) begin
         fill_ff <= fill_in;
         last_ff <= last_in;
      end
   end

   assign cells = cells_ff;
   assign fill  = fill_ff;
   assign last  = last_ff;

endmodule

@@ design/msdw_scan.sv @@
// parallel duplicate compares and group partial sums over the window
module msdw_scan import msdw_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int VALUE_BITS = 20,
   localparam int KW = $clog2(WINDOW_MAX + 1),
   localparam int GROUP = 8,
   localparam int NG = (WINDOW_MAX + GROUP - 1) / GROUP,
   localparam int GW = VALUE_BITS + 3
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [WINDOW_MAX-1:0][VALUE_BITS-1:0] cells,
   input  logic [KW-1:0]                        fill,
   input  logic [KW-1:0]                        win_len,
   input  logic                                 last,
   output logic [WINDOW_MAX-1:0]                row_dup,
   output logic [NG-1:0][GW-1:0]                group_sum,
   output msdw_tag_type                         tag
);

   logic [KW-1:0]               held;
   logic [WINDOW_MAX-1:0]       member;
   logic [WINDOW_MAX-1:0]       row_dup_in;
   logic [NG-1:0][GW-1:0]       group_sum_in;
   msdw_tag_type                tag_in;
   logic [WINDOW_MAX-1:0]       row_dup_ff;
   logic [NG-1:0][GW-1:0]       group_sum_ff;
   msdw_tag_type                tag_ff;

   assign held = (fill < win_len) ? fill : win_len;

   always_comb begin
      for (int a = 0; a < WINDOW_MAX; a++) begin
         member[a] = KW'(a) < held;
      end
   end

   // membership is a prefix, so a member at b implies a member at every a below it
   always_comb begin
      for (int a = 0; a < WINDOW_MAX; a++) begin
         row_dup_in[a] = 1'b0;
         for (int b = a + 1; b < WINDOW_MAX; b++) begin
            if (member[b] && (cells[a] == cells[b])) begin
               row_dup_in[a] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_sum_in[g] = '0;
         for (int i = 0; i < GROUP; i++) begin
            if ((g * GROUP + i < WINDOW_MAX) && member[g * GROUP + i]) begin
               group_sum_in[g] = group_sum_in[g] + GW'(cells[g * GROUP + i]);
            end
         end
      end
   end

   always_comb begin
      tag_in.last = last;
      tag_in.full = fill >= win_len;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_dup_ff   <= row_dup_in;
         group_sum_ff <= group_sum_in;
         tag_ff       <= tag_in;
      end
   end

   assign row_dup   = row_dup_ff;
   assign group_sum = group_sum_ff;
   assign tag       = tag_ff;

endmodule

@@ design/msdw_reduce.sv @@
// folds the scan results into window sum and distinct-full flag
module msdw_reduce import msdw_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int VALUE_BITS = 20,
   localparam int GROUP = 8,
   localparam int NG = (WINDOW_MAX + GROUP - 1) / GROUP,
   localparam int GW = VALUE_BITS + 3,
   localparam int SW = VALUE_BITS + ((WINDOW_MAX > GROUP) ? $clog2(WINDOW_MAX) : 3)
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic [WINDOW_MAX-1:0]   row_dup,
   input  logic [NG-1:0][GW-1:0]   group_sum,
   input  msdw_tag_type            tag,
   output logic [SW-1:0]           sum,
   output logic                    ok,
   output logic                    last
);

   logic [SW-1:0] sum_in;
   logic          ok_in;
   logic [SW-1:0] sum_ff;
   logic          ok_ff;
   logic          last_ff;

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NG; g++) begin
         sum_in = sum_in + SW'(group_sum[g]);
      end
      ok_in = tag.full && !(|row_dup);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff  <= sum_in;
         ok_ff   <= ok_in;
         last_ff <= tag.last;
      end
   end

   assign sum  = sum_ff;
   assign ok   = ok_ff;
   assign last = last_ff;

endmodule

@@ design/max_sum_distinct_window.sv @@
// top level of the distinct sliding-window maximum sum block
//
// usage:
//   req channel (req_valid/req_ready/req_payload) carries one array value per
//   transaction, with a last flag on the final value of a sequence
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns exactly one result
//   per request transaction, in order: best sum so far, current window sum,
//   window-ok flag and an echo of last (best_sum is then the sequence answer)
//   csr_write_en/csr_write_data set the window length; write it only while
//   no transaction is in flight. zero behaves as one, above WINDOW_MAX saturates
// pipeline: the window register loads at request acceptance, then the
//   compare/partial-sum stage, reduce stage and result register follow in turn
// throughput: one transaction per cycle when not stalled; the compare matrix over
//   the window cells and the partial-sum tree are fully parallel, so nothing iterates
// reset: synchronous, clears the window, best sum and pipeline; length goes to 1
// stalls: each stage holds while the next one is full, so up to three more
//   requests are taken while a result waits in the output register, after
//   which req_ready drops until rsp_ready returns
module max_sum_distinct_window import msdw_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int VALUE_BITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  msdw_req_type     req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output msdw_rsp_type     rsp_payload,
   input  logic             csr_write_en,
   input  logic [LEN_W-1:0] csr_write_data
);

   localparam int KW    = $clog2(WINDOW_MAX + 1);
   localparam int LW    = LEN_W + KW;
   localparam int GROUP = 8;
   localparam int NG    = (WINDOW_MAX + GROUP - 1) / GROUP;
   localparam int GW    = VALUE_BITS + 3;
   localparam int SW    = VALUE_BITS + ((WINDOW_MAX > GROUP) ? $clog2(WINDOW_MAX) : 3);

   // configuration
   logic [LEN_W-1:0] len_ff;
   logic [LW-1:0]    len_wide;
   logic [KW-1:0]    win_len;

   // pipeline occupancy
   logic s0_valid_ff;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s2_free;
   logic s1_free;
   logic s2_move;
   logic s1_move;
   logic s0_move;
   logic req_take;

   // datapath
   logic [VALUE_BITS-1:0]                  value_in;
   logic [WINDOW_MAX-1:0][VALUE_BITS-1:0]  cells;
   logic [KW-1:0]                          fill;
   logic                                   s0_last;
   logic [WINDOW_MAX-1:0]                  row_dup;
   logic [NG-1:0][GW-1:0]                  group_sum;
   msdw_tag_type                           s1_tag;
   logic [SW-1:0]                          s2_sum;
   logic                                   s2_ok;
   logic                                   s2_last;
   logic [SW-1:0]                          best_ff;
   logic [SW-1:0]                          best_in;
   logic [SUM_W-1:0]                       best_out;
   logic [SUM_W-1:0]                       sum_out;
   msdw_rsp_type                           rsp_ff;

   // window length register, written without handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else if (csr_write_en) begin
         len_ff <= csr_write_data;
      end
   end

   // effective window length: zero means one, anything above the depth saturates
   assign len_wide = {{KW{1'b0}}, len_ff};
   always_comb begin
      if (len_wide == '0) begin
         win_len = KW'(1);
      end else if (len_wide > LW'(WINDOW_MAX)) begin
         win_len = KW'(WINDOW_MAX);
      end else begin
         win_len = len_wide[KW-1:0];
      end
   end

   // value width follows the parameter: high bits dropped or zeros added
   if (VALUE_BITS <= VALUE_W) begin : g_val_trim
      assign value_in = req_payload.value[VALUE_BITS-1:0];
   end else begin : g_val_ext
      assign value_in = {{(VALUE_BITS - VALUE_W){1'b0}}, req_payload.value};
   end

   // per-stage ready chain, each stage moves when the one after it has room
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s2_move   = s2_valid_ff && out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s0_move   = s0_valid_ff && s1_free;
   assign req_ready = !s0_valid_ff || s1_free;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s0_valid_ff <= 1'b1;
         end else if (s0_move) begin
            s0_valid_ff <= 1'b0;
         end
         if (s0_move) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stage 0: the window itself, shifted on every accepted transaction
   msdw_window #(
      .WINDOW_MAX (WINDOW_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .value_in (value_in),
      .last_in  (req_payload.last),
      .cells    (cells),
      .fill     (fill),
      .last     (s0_last)
   );

   // stage 1: pairwise compares and partial sums
   msdw_scan #(
      .WINDOW_MAX (WINDOW_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_scan (
      .clock     (clock),
      .load      (s0_move),
      .cells     (cells),
      .fill      (fill),
      .win_len   (win_len),
      .last      (s0_last),
      .row_dup   (row_dup),
      .group_sum (group_sum),
      .tag       (s1_tag)
   );

   // stage 2: window sum and distinct-full flag
   msdw_reduce #(
      .WINDOW_MAX (WINDOW_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_reduce (
      .clock     (clock),
      .load      (s1_move),
      .row_dup   (row_dup),
      .group_sum (group_sum),
      .tag       (s1_tag),
      .sum       (s2_sum),
      .ok        (s2_ok),
      .last      (s2_last)
   );

   // stage 3: running best, compared at full width before the output trim
   assign best_in = (s2_ok && (s2_sum > best_ff)) ? s2_sum : best_ff;

   if (SW >= SUM_W) begin : g_out_trim
      assign best_out = best_in[SUM_W-1:0];
      assign sum_out  = s2_sum[SUM_W-1:0];
   end else begin : g_out_ext
      assign best_out = {{(SUM_W - SW){1'b0}}, best_in};
      assign sum_out  = {{(SUM_W - SW){1'b0}}, s2_sum};
   end

   // best clears once the last transaction of a sequence has been scored
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (s2_move) begin
         best_ff <= s2_last ? '0 : best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_ff.best_sum   <= best_out;
         rsp_ff.window_sum <= sum_out;
         rsp_ff.window_ok  <= s2_ok;
         rsp_ff.final_res  <= s2_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // the running best never falls below an accepted candidate
   a_best_covers_ok: assert property (@(posedge clock) disable iff (reset)
      s2_move && s2_ok |-> best_in >= s2_sum)
      else $error("best sum below a distinct full window sum");

   // best is zero once the end of a sequence has been scored
   a_best_clears: assert property (@(posedge clock) disable iff (reset)
      s2_move && s2_last |=> best_ff == '0)
      else $error("best sum not cleared after last transaction");

   // a new sequence restarts the window with one value held
   a_fill_restart: assert property (@(posedge clock) disable iff (reset)
      req_take && s0_last |=> fill == KW'(1))
      else $error("fill count not restarted after last transaction");

   // back-pressure only when every stage is occupied and the output is stalled
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s0_valid_ff && s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled with room in the pipeline");
`endif

endmodule

@@ dv/tb_max_sum_distinct_window.sv @@
// self-checking testbench for the distinct sliding-window maximum sum block
module tb_max_sum_distinct_window;
   timeunit 1ns;
   timeprecision 1ps;

   import msdw_pkg::*;

   localparam int WIN_MAX      = 64;
   localparam int RANDOM_ITEMS = 1830;
   // covers the four pipeline stages with margin
   localparam int DRAIN_CYCLES = 8;
   // roughly 1850 transactions, each with a possible sender gap and receiver
   // stall, plus drains around every length change, many times over
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 40;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;
   typedef enum logic [1:0] {SEQ_POOL, SEQ_RUN, SEQ_WIDE} seq_kind_type;

   // one row of the directed table: either a window length write or a value,
   // with the expected result typed in where it is obvious
   typedef struct packed {
      row_kind_type       kind;
      logic [VALUE_W-1:0] data;
      logic               last;
      logic               typed;
      msdw_rsp_type       want;
   } dir_row_type;

   localparam int DIR_ROWS = 26;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // length 1 straight out of reset, zero and full-scale values
      '{ROW_ITEM, 20'h00000, 1'b0, 1'b1, '{26'h0000000, 26'h0000000, 1'b1, 1'b0}},
      '{ROW_ITEM, 20'hFFFFF, 1'b1, 1'b1, '{26'h00FFFFF, 26'h00FFFFF, 1'b1, 1'b1}},
      // zero length behaves as one
      '{ROW_CFG,  20'd0,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd5,     1'b0, 1'b1, '{26'd5, 26'd5, 1'b1, 1'b0}},
      '{ROW_ITEM, 20'd3,     1'b1, 1'b1, '{26'd5, 26'd3, 1'b1, 1'b1}},
      // length 3: fill, distinct window, duplicates, recovery
      '{ROW_CFG,  20'd3,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd1,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd2,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd3,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd3,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd9,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd8,     1'b1, 1'b0, '0},
      // length grows mid-sequence, then shrinks again
      '{ROW_CFG,  20'd2,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd4,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd6,     1'b0, 1'b0, '0},
      '{ROW_CFG,  20'd4,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd4,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd8,     1'b0, 1'b0, '0},
      '{ROW_CFG,  20'd1,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd8,     1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'd0,     1'b1, 1'b0, '0},
      // oversize length saturates, window never fills here
      '{ROW_CFG,  20'd127,   1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'hFFFFF, 1'b0, 1'b1, '{26'h0000000, 26'h00FFFFF, 1'b0, 1'b0}},
      '{ROW_ITEM, 20'hFFFFE, 1'b1, 1'b1, '{26'h0000000, 26'h01FFFFD, 1'b0, 1'b1}},
      '{ROW_CFG,  20'd64,    1'b0, 1'b0, '0},
      '{ROW_ITEM, 20'h00000, 1'b1, 1'b1, '{26'h0000000, 26'h0000000, 1'b0, 1'b1}}
   };

   // block ports; the inputs driven here are known from time zero
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   msdw_req_type       req_payload    = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   msdw_rsp_type       rsp_payload;
   logic               csr_write_en   = 1'b0;
   logic [LEN_W-1:0]   csr_write_data = '0;

   // predictor state: newest value in cell 0
   logic [VALUE_W-1:0] win_cells [WIN_MAX];
   int                 win_fill;
   logic [SUM_W-1:0]   win_best;
   logic [LEN_W-1:0]   win_len;

   // expected results in transaction order
   msdw_rsp_type       pending_windows [$];

   // run bookkeeping
   bit                 valid_up;
   bit                 send_idle_on;
   bit                 recv_idle_on;
   int                 rsp_stall_left;
   int                 cycle_count;
   int                 mismatches;
   int                 results_seen;
   int                 windows_ok_seen;
   int                 values_sent;
   int                 sequences_closed;
   int                 lengths_written;

   max_sum_distinct_window #(
      .WINDOW_MAX (WIN_MAX),
      .VALUE_BITS (VALUE_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // end of a sequence (and reset) empties the whole window and the best sum
   function automatic void clear_window();
      int i;
      for (i = 0; i < WIN_MAX; i++) win_cells[i] = '0;
      win_fill = 0;
      win_best = '0;
   endfunction

   // zero acts as one, anything above the cell count saturates
   function automatic int effective_length(input logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > WIN_MAX) return WIN_MAX;
      return int'(len);
   endfunction

   // shift one value in and work out the result it produces
   function automatic msdw_rsp_type predict_window(input logic [VALUE_W-1:0] v,
                                                   input logic l);
      msdw_rsp_type     r;
      int               k, held, pairs, i, j;
      logic [SUM_W-1:0] sum;
      logic             ok;
      k = effective_length(win_len);
      for (i = WIN_MAX - 1; i > 0; i--) win_cells[i] = win_cells[i-1];
      win_cells[0] = v;
      if (win_fill < WIN_MAX) win_fill++;
      // while filling, the window is whatever has arrived so far
      held = (win_fill < k) ? win_fill : k;
      sum = '0;
      pairs = 0;
      for (i = 0; i < held; i++) begin
         sum = sum + SUM_W'(win_cells[i]);
         for (j = i + 1; j < held; j++) begin
            if (win_cells[j] == win_cells[i]) pairs++;
         end
      end
      ok = (win_fill >= k) && (pairs == 0);
      if (ok && sum > win_best) win_best = sum;
      r.best_sum   = win_best;
      r.window_sum = sum;
      r.window_ok  = ok;
      r.final_res  = l;
      if (l) clear_window();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                  results_seen, what, got, want);
   endtask

   // hold the sender off until every result is back and the pipe is empty
   task automatic drain_results();
      if (valid_up) req_valid <= 1'b0;
      valid_up = 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // length writes only ever happen with the block idle
   task automatic write_length(input logic [LEN_W-1:0] len);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      win_len = len;
      @(posedge clock);
      csr_write_en <= 1'b0;
      lengths_written++;
   endtask

   // one request transaction; valid stays up if the next one follows at once
   task automatic send_value(input logic [VALUE_W-1:0] v, input logic l,
                             input logic typed, input msdw_rsp_type want);
      msdw_rsp_type predicted;
      int           gap;
      gap = send_idle_on ? $urandom_range(6) : 0;
      if (gap > 0) begin
         if (valid_up) req_valid <= 1'b0;
         valid_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{value: v, last: l};
      valid_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      // the predictor always runs so its state tracks the block,
      // but a typed-in expectation takes precedence in the queue
      predicted = predict_window(v, l);
      pending_windows.push_back(typed ? want : predicted);
      values_sent++;
      if (l) sequences_closed++;
   endtask

   // response side: check each transaction, then stall for a drawn number of cycles
   always @(posedge clock) begin
      msdw_rsp_type want;
      int           stall;
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_windows.size() == 0) begin
            report_mismatch("result with nothing outstanding",
                            32'(rsp_payload.window_sum), 32'(0));
         end else begin
            want = pending_windows.pop_front();
            if (rsp_payload.best_sum !== want.best_sum)
               report_mismatch("best_sum", 32'(rsp_payload.best_sum), 32'(want.best_sum));
            if (rsp_payload.window_sum !== want.window_sum)
               report_mismatch("window_sum", 32'(rsp_payload.window_sum),
                               32'(want.window_sum));
            if (rsp_payload.window_ok !== want.window_ok)
               report_mismatch("window_ok", 32'(rsp_payload.window_ok),
                               32'(want.window_ok));
            if (rsp_payload.final_res !== want.final_res)
               report_mismatch("final_res", 32'(rsp_payload.final_res),
                               32'(want.final_res));
         end
         results_seen++;
         if (rsp_payload.window_ok === 1'b1) windows_ok_seen++;
         stall = recv_idle_on ? $urandom_range(6) : 0;
         if (stall == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready      <= 1'b0;
            rsp_stall_left <= stall;
         end
      end else if (!rsp_ready) begin
         if (rsp_stall_left <= 1) rsp_ready <= 1'b1;
         else rsp_stall_left <= rsp_stall_left - 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, pending_windows.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                 row, random_sent, phase_left, effk, seq_left, seq_pos, seq_pool;
      seq_kind_type       seq_kind;
      logic [VALUE_W-1:0] seq_base, prev_value, v;
      logic [LEN_W-1:0]   len;

      win_len = LEN_W'(1);
      clear_window();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIR_ROWS; row++) begin
         if (DIR_TABLE[row].kind == ROW_CFG)
            write_length(DIR_TABLE[row].data[LEN_W-1:0]);
         else
            send_value(DIR_TABLE[row].data, DIR_TABLE[row].last,
                       DIR_TABLE[row].typed, DIR_TABLE[row].want);
      end

      // random phases: each picks a length, then streams sequences whose
      // values are built to give both distinct and repeating windows; a
      // sequence cut off by the end of a phase carries on under the new length
      random_sent = 0;
      seq_left    = 0;
      seq_pos     = 0;
      seq_pool    = 1;
      seq_kind    = SEQ_WIDE;
      seq_base    = '0;
      prev_value  = '0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(11))
            0:       len = '0;
            1:       len = LEN_W'(1);
            2:       len = LEN_W'(WIN_MAX);
            3:       len = '1;
            4:       len = LEN_W'($urandom_range(126, 65));
            5, 6:    len = LEN_W'($urandom_range(32, 9));
            default: len = LEN_W'($urandom_range(8, 2));
         endcase
         write_length(len);
         effk = effective_length(len);
         // some phases run flat out on one or both sides
         send_idle_on = ($urandom_range(3) != 0);
         recv_idle_on = ($urandom_range(3) != 0);
         phase_left = 2 * effk + $urandom_range(60, 20);
         while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
            if (seq_left == 0) begin
               // occasionally let everything drain between sequences
               if ($urandom_range(7) == 0) drain_results();
               seq_kind = seq_kind_type'($urandom_range(2));
               // mostly long enough to fill the window, some cut short
               if ($urandom_range(4) == 0) seq_left = $urandom_range(effk, 1);
               else seq_left = $urandom_range(3 * effk + 4, effk);
               seq_pool = effk + $urandom_range(3);
               case ($urandom_range(3))
                  0:       seq_base = '1;
                  1:       seq_base = VALUE_W'(seq_pool - 1);
                  default: seq_base = VALUE_W'($urandom);
               endcase
               seq_pos = 0;
            end
            case (seq_kind)
               // random picks from a small pool: duplicates are common
               SEQ_POOL: v = seq_base - VALUE_W'($urandom_range(seq_pool - 1));
               // periodic run, distinct over any window, with the odd repeat
               SEQ_RUN: begin
                  if ($urandom_range(11) == 0) v = prev_value;
                  else v = seq_base - VALUE_W'(seq_pos % seq_pool);
               end
               default: v = VALUE_W'($urandom);
            endcase
            seq_left--;
            seq_pos++;
            phase_left--;
            random_sent++;
            send_value(v, seq_left == 0, 1'b0, '0);
            prev_value = v;
         end
      end

      drain_results();
      $display("%0d values in %0d closed sequences under %0d window length writes",
               values_sent, sequences_closed, lengths_written);
      $display("%0d results checked, %0d of them full distinct windows, %0d mismatches",
               results_seen, windows_ok_seen, mismatches);
      if (mismatches == 0 && pending_windows.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
